// ===== hdl/dpgv_pkg.sv =====
// dpgv_pkg: shared types, constants and command codes of the dual-path verifier.
// No dependencies; used by dpgv_ctrl, dpgv_dp and dual_path_goose_verifier.
package dpgv_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int TAG_BITS_DEF = 16;

    localparam logic [31:0] TIMEOUT_RESET = 32'd3000000;
    localparam logic [15:0] ETH_GOOSE     = 16'h88B8;
    localparam logic [15:0] ETH_VLAN      = 16'h8100;

    localparam logic [2:0] DISP_FWD     = 3'd0;
    localparam logic [2:0] DISP_DROP    = 3'd1;
    localparam logic [2:0] DISP_STALE   = 3'd2;
    localparam logic [2:0] DISP_BUF     = 3'd3;
    localparam logic [2:0] DISP_EXPIRE  = 3'd4;
    localparam logic [2:0] DISP_OVFL    = 3'd5;
    localparam logic [2:0] DISP_LOOP    = 3'd6;

    localparam logic [2:0] CLS_LOOP     = 3'd0;
    localparam logic [2:0] CLS_FOREIGN  = 3'd1;
    localparam logic [2:0] CLS_DROP     = 3'd2;
    localparam logic [2:0] CLS_STALE    = 3'd3;
    localparam logic [2:0] CLS_FWD      = 3'd4;
    localparam logic [2:0] CLS_MATCH    = 3'd5;

    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_SCAN      = 4'd2;
    localparam logic [3:0] OP_NEXT      = 4'd3;
    localparam logic [3:0] OP_EXPIRE    = 4'd4;
    localparam logic [3:0] OP_MATCH     = 4'd5;
    localparam logic [3:0] OP_STORE     = 4'd6;
    localparam logic [3:0] OP_FWD       = 4'd7;
    localparam logic [3:0] OP_EMIT      = 4'd8;
    localparam logic [3:0] OP_FLUSH     = 4'd9;

    typedef struct packed {
        logic [1:0]  path;
        logic [47:0] now_ns;
        logic [15:0] ether_type;
        logic [30:0] state_number;
        logic [30:0] sequence_number;
        logic [7:0]  flag_byte;
        logic [15:0] packet_tag;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  disposition;
        logic [15:0] tag_out;
        logic [30:0] state_out;
        logic [30:0] sequence_out;
        logic [7:0]  flag_out;
        logic        last_result;
    } out_word_t;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] disp;
        logic       scan_path;
    } cmd_t;

    typedef struct packed {
        logic [2:0] cls;
        logic       in_range;
        logic       too_old;
        logic       match;
        logic       own_full;
        logic       can_emit;
        logic       out_free;
        logic       scan_path;
        logic       other_path;
    } sts_t;

endpackage

// ===== hdl/dpgv_ctrl.sv =====
// dpgv_ctrl: sequencing state machine of the verifier.
// Depends on dpgv_pkg; drives dpgv_dp through cmd_t, reads sts_t.
module dpgv_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  dpgv_pkg::sts_t sts,
    output dpgv_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLASS = 3'd1;
    localparam logic [2:0] ST_MATCH = 3'd2;
    localparam logic [2:0] ST_STORE = 3'd3;
    localparam logic [2:0] ST_OWN   = 3'd4;
    localparam logic [2:0] ST_SWEEP = 3'd5;
    localparam logic [2:0] ST_FLUSH = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] disp_reg, disp_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        disp_next     = disp_reg;
        cmd.op        = dpgv_pkg::OP_NONE;
        cmd.disp      = disp_reg;
        cmd.scan_path = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = dpgv_pkg::OP_LOAD;
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS:
            begin
                unique case (sts.cls)
                    dpgv_pkg::CLS_LOOP:
                    begin
                        cmd.op     = dpgv_pkg::OP_EMIT;
                        cmd.disp   = dpgv_pkg::DISP_LOOP;
                        state_next = ST_FLUSH;
                    end
                    dpgv_pkg::CLS_FOREIGN:
                    begin
                        cmd.op     = dpgv_pkg::OP_EMIT;
                        cmd.disp   = dpgv_pkg::DISP_DROP;
                        state_next = ST_FLUSH;
                    end
                    dpgv_pkg::CLS_STALE:
                    begin
                        disp_next  = dpgv_pkg::DISP_STALE;
                        state_next = ST_OWN;
                    end
                    dpgv_pkg::CLS_FWD:
                    begin
                        cmd.op     = dpgv_pkg::OP_FWD;
                        disp_next  = dpgv_pkg::DISP_FWD;
                        state_next = ST_OWN;
                    end
                    dpgv_pkg::CLS_MATCH:
                    begin
                        cmd.op        = dpgv_pkg::OP_SCAN;
                        cmd.scan_path = sts.other_path;
                        state_next    = ST_MATCH;
                    end
                    default:
                    begin
                        disp_next  = dpgv_pkg::DISP_DROP;
                        state_next = ST_OWN;
                    end
                endcase
            end
            ST_MATCH:
            begin
                priority if (!sts.in_range)
                    state_next = ST_STORE;
                else if (sts.too_old)
                begin
                    if (sts.can_emit)
                        cmd.op = dpgv_pkg::OP_EXPIRE;
                end
                else if (sts.match)
                begin
                    cmd.op     = dpgv_pkg::OP_MATCH;
                    disp_next  = dpgv_pkg::DISP_FWD;
                    state_next = ST_OWN;
                end
                else
                    cmd.op = dpgv_pkg::OP_NEXT;
            end
            ST_STORE:
            begin
                if (sts.own_full)
                    disp_next = dpgv_pkg::DISP_OVFL;
                else
                begin
                    cmd.op    = dpgv_pkg::OP_STORE;
                    disp_next = dpgv_pkg::DISP_BUF;
                end
                state_next = ST_OWN;
            end
            ST_OWN:
            begin
                if (sts.can_emit)
                begin
                    cmd.op     = dpgv_pkg::OP_EMIT;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                priority if (!sts.in_range)
                begin
                    if (!sts.scan_path)
                    begin
                        cmd.op        = dpgv_pkg::OP_SCAN;
                        cmd.scan_path = 1'b1;
                    end
                    else
                        state_next = ST_FLUSH;
                end
                else if (sts.too_old)
                begin
                    if (sts.can_emit)
                        cmd.op = dpgv_pkg::OP_EXPIRE;
                end
                else
                    cmd.op = dpgv_pkg::OP_NEXT;
            end
            ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = dpgv_pkg::OP_FLUSH;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            disp_reg  <= dpgv_pkg::DISP_DROP;
        end
        else
        begin
            state_reg <= state_next;
            disp_reg  <= disp_next;
        end
    end

endmodule

// ===== hdl/dpgv_dp.sv =====
// dpgv_dp: message register, reference state, two pending buffers and output stages.
// Depends on dpgv_pkg; commanded by dpgv_ctrl.
module dpgv_dp #(
    parameter int BUF_DEPTH = dpgv_pkg::DEPTH_DEF,
    parameter int TAG_BITS  = dpgv_pkg::TAG_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dpgv_pkg::in_word_t  in_data,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata,
    input  dpgv_pkg::cmd_t      cmd,
    output dpgv_pkg::sts_t      sts,
    output logic                out_valid,
    input  logic                out_ready,
    output dpgv_pkg::out_word_t out_data
);

    localparam int TB = (TAG_BITS < 16) ? TAG_BITS : 16;
    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam int IW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    typedef struct packed {
        logic [47:0]   time_ns;
        logic [30:0]   st;
        logic [30:0]   sq;
        logic [7:0]    flag;
        logic [TB-1:0] tag;
    } entry_t;

    dpgv_pkg::in_word_t  msg_reg;
    dpgv_pkg::out_word_t hold_reg, out_reg, new_word, flush_word;
    logic                hold_valid_reg, out_valid_reg;
    logic [31:0]         timeout_reg;
    logic                have_ref_reg;
    logic [30:0]         ref_st_reg, ref_sq_reg;
    logic [7:0]          ref_flag_reg;
    logic [CW-1:0]       cnta_reg, cntb_reg, idx_reg, cnt_sel, cnt_own;
    logic                scan_path_reg;
    entry_t              bufa_reg [BUF_DEPTH];
    entry_t              bufb_reg [BUF_DEPTH];
    entry_t              sel, ins;
    logic [47:0]         age;
    logic                emit, remove_a, remove_b, store_a, store_b;
    logic [TB-1:0]       tag_m;
    logic [2:0]          cls;

    assign tag_m   = msg_reg.packet_tag[TB-1:0];
    assign sel     = scan_path_reg ? bufb_reg[idx_reg[IW-1:0]] : bufa_reg[idx_reg[IW-1:0]];
    assign cnt_sel = scan_path_reg ? cntb_reg : cnta_reg;
    assign cnt_own = msg_reg.path[0] ? cntb_reg : cnta_reg;
    assign age     = msg_reg.now_ns - sel.time_ns;
    assign ins     = '{time_ns: msg_reg.now_ns, st: msg_reg.state_number,
                       sq: msg_reg.sequence_number, flag: msg_reg.flag_byte, tag: tag_m};

    always_comb
    begin
        priority if (msg_reg.path[1])
            cls = dpgv_pkg::CLS_LOOP;
        else if (msg_reg.ether_type != dpgv_pkg::ETH_GOOSE
                 && msg_reg.ether_type != dpgv_pkg::ETH_VLAN)
            cls = dpgv_pkg::CLS_FOREIGN;
        else if (msg_reg.flag_byte > 8'd1)
            cls = dpgv_pkg::CLS_DROP;
        else if (!have_ref_reg)
            cls = dpgv_pkg::CLS_MATCH;
        else if (msg_reg.state_number == ref_st_reg && msg_reg.sequence_number > ref_sq_reg
                 && msg_reg.flag_byte == ref_flag_reg)
            cls = dpgv_pkg::CLS_FWD;
        else if (msg_reg.state_number == ref_st_reg && msg_reg.sequence_number <= ref_sq_reg)
            cls = dpgv_pkg::CLS_STALE;
        else if (msg_reg.state_number > ref_st_reg
                 && (ref_flag_reg ^ msg_reg.flag_byte) == 8'd1)
            cls = dpgv_pkg::CLS_MATCH;
        else
            cls = dpgv_pkg::CLS_DROP;
    end

    assign sts.cls        = cls;
    assign sts.in_range   = idx_reg < cnt_sel;
    assign sts.too_old    = age > {16'd0, timeout_reg};
    assign sts.match      = sel.st == msg_reg.state_number && sel.flag == msg_reg.flag_byte;
    assign sts.own_full   = cnt_own == CW'(BUF_DEPTH);
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.can_emit   = !hold_valid_reg || sts.out_free;
    assign sts.scan_path  = scan_path_reg;
    assign sts.other_path = !msg_reg.path[0];

    always_comb
    begin
        if (cmd.op == dpgv_pkg::OP_EXPIRE)
        begin
            new_word.disposition  = dpgv_pkg::DISP_EXPIRE;
            new_word.tag_out      = 16'(sel.tag);
            new_word.state_out    = sel.st;
            new_word.sequence_out = sel.sq;
            new_word.flag_out     = sel.flag;
        end
        else
        begin
            new_word.disposition  = cmd.disp;
            new_word.tag_out      = 16'(tag_m);
            new_word.state_out    = msg_reg.state_number;
            new_word.sequence_out = msg_reg.sequence_number;
            new_word.flag_out     = msg_reg.flag_byte;
        end
        new_word.last_result = 1'b0;
    end

    always_comb
    begin
        flush_word             = hold_reg;
        flush_word.last_result = 1'b1;
    end

    assign emit     = cmd.op == dpgv_pkg::OP_EMIT || cmd.op == dpgv_pkg::OP_EXPIRE;
    assign remove_a = (cmd.op == dpgv_pkg::OP_EXPIRE || cmd.op == dpgv_pkg::OP_MATCH)
                      && !scan_path_reg;
    assign remove_b = (cmd.op == dpgv_pkg::OP_EXPIRE || cmd.op == dpgv_pkg::OP_MATCH)
                      && scan_path_reg;
    assign store_a  = cmd.op == dpgv_pkg::OP_STORE && !msg_reg.path[0];
    assign store_b  = cmd.op == dpgv_pkg::OP_STORE && msg_reg.path[0];

    always_ff @(posedge clk)
    begin
        if (cmd.op == dpgv_pkg::OP_LOAD)
            msg_reg <= in_data;
        if (emit)
            hold_reg <= new_word;
        if (emit && hold_valid_reg)
            out_reg <= hold_reg;
        else if (cmd.op == dpgv_pkg::OP_FLUSH)
            out_reg <= flush_word;
        for (int j = 0; j < BUF_DEPTH - 1; j++)
        begin
            if (remove_a && CW'(j) >= idx_reg)
                bufa_reg[j] <= bufa_reg[j + 1];
            if (remove_b && CW'(j) >= idx_reg)
                bufb_reg[j] <= bufb_reg[j + 1];
        end
        if (store_a)
            bufa_reg[cnta_reg[IW-1:0]] <= ins;
        if (store_b)
            bufb_reg[cntb_reg[IW-1:0]] <= ins;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= dpgv_pkg::TIMEOUT_RESET;
            have_ref_reg   <= 1'b0;
            ref_st_reg     <= '0;
            ref_sq_reg     <= '0;
            ref_flag_reg   <= '0;
            cnta_reg       <= '0;
            cntb_reg       <= '0;
            idx_reg        <= '0;
            scan_path_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                timeout_reg <= cfg_wdata;
            if (cmd.op == dpgv_pkg::OP_FWD)
                ref_sq_reg <= msg_reg.sequence_number;
            if (cmd.op == dpgv_pkg::OP_MATCH)
            begin
                have_ref_reg <= 1'b1;
                ref_st_reg   <= msg_reg.state_number;
                ref_sq_reg   <= msg_reg.sequence_number;
                ref_flag_reg <= msg_reg.flag_byte;
            end
            if (remove_a)
                cnta_reg <= cnta_reg - 1'b1;
            else if (store_a)
                cnta_reg <= cnta_reg + 1'b1;
            if (remove_b)
                cntb_reg <= cntb_reg - 1'b1;
            else if (store_b)
                cntb_reg <= cntb_reg + 1'b1;
            if (cmd.op == dpgv_pkg::OP_SCAN)
            begin
                scan_path_reg <= cmd.scan_path;
                idx_reg       <= '0;
            end
            else if (cmd.op == dpgv_pkg::OP_EMIT)
            begin
                scan_path_reg <= 1'b0;
                idx_reg       <= '0;
            end
            else if (cmd.op == dpgv_pkg::OP_NEXT)
                idx_reg <= idx_reg + 1'b1;
            if (emit)
                hold_valid_reg <= 1'b1;
            else if (cmd.op == dpgv_pkg::OP_FLUSH)
                hold_valid_reg <= 1'b0;
            if ((emit && hold_valid_reg) || cmd.op == dpgv_pkg::OP_FLUSH)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnta_reg <= CW'(BUF_DEPTH) && cntb_reg <= CW'(BUF_DEPTH))
        else $error("buffer count beyond depth");
    a_flush_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == dpgv_pkg::OP_FLUSH |-> hold_valid_reg && sts.out_free)
        else $error("flush without pending word");
    a_expire_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == dpgv_pkg::OP_EXPIRE |-> sts.in_range && sts.can_emit)
        else $error("expiry outside buffer");
    a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == dpgv_pkg::OP_STORE |-> !sts.own_full)
        else $error("store into full buffer");
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit && hold_valid_reg |-> !out_valid_reg || out_ready)
        else $error("output word overwritten");

endmodule

// ===== hdl/dual_path_goose_verifier.sv =====
// dual_path_goose_verifier: top level, state machine plus datapath.
// Depends on dpgv_pkg, dpgv_ctrl and dpgv_dp.
//
//   channel   direction  handshake            word
//   in        input      in_valid/in_ready    dpgv_pkg::in_word_t
//   out       output     out_valid/out_ready  dpgv_pkg::out_word_t
//   cfg       input      cfg_we               cfg_wdata (timeout_ns)
//
// One message at a time: loopback and foreign types are emitted and flushed straight
// after classification; others emit their own word and then sweep both buffers for
// expired entries, and when matching first scan the other path's buffer entry by entry.
// Reset clears buffers to empty and timeout to 3 ms; no clearing pass is needed.
// A stalled output holds the state machine only on steps that produce a word.
module dual_path_goose_verifier #(
    parameter int BUF_DEPTH = dpgv_pkg::DEPTH_DEF,
    parameter int TAG_BITS  = dpgv_pkg::TAG_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dpgv_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dpgv_pkg::out_word_t out_data,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata
);

    dpgv_pkg::cmd_t cmd;
    dpgv_pkg::sts_t sts;

    dpgv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dpgv_dp #(
        .BUF_DEPTH (BUF_DEPTH),
        .TAG_BITS  (TAG_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
